// File: hdl/tes_pkg.sv
// Shared types, codes and helper functions of the timed event scheduler.
`default_nettype none
package tes_pkg;

    localparam int MAIN_DEPTH_DEF  = 16;
    localparam int ROUND_DEPTH_DEF = 8;
    localparam int IDLE_DEPTH_DEF  = 8;
    localparam int MAX_RESULTS     = 16;

    localparam logic [2:0] ACT_ADD       = 3'd0;
    localparam logic [2:0] ACT_ADD_ROUND = 3'd1;
    localparam logic [2:0] ACT_ADD_IDLE  = 3'd2;
    localparam logic [2:0] ACT_TICK      = 3'd3;
    localparam logic [2:0] ACT_FORCE     = 3'd4;
    localparam logic [2:0] ACT_CLEAR     = 3'd5;

    localparam logic [1:0] KIND_DONE  = 2'd0;
    localparam logic [1:0] KIND_FIRED = 2'd1;
    localparam logic [1:0] KIND_NONE  = 2'd2;
    localparam logic [1:0] KIND_FULL  = 2'd3;

    localparam logic [32:0] TIMEOUT_NONE = 33'h0_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] due;
        logic [15:0] id;
        logic [15:0] stamp;
    } t_entry;

    typedef struct packed {
        logic [2:0]  action;
        logic [15:0] id;
        logic [31:0] due;
        logic [31:0] now;
    } t_cmd;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MERGE, ST_IMIN, ST_ISCAN, ST_IMOVE,
        ST_FMIN, ST_FDEC, ST_REMOVE, ST_SUM, ST_EMIT
    } t_state;

    // True when entry a leaves before entry b; equal due times go by age.
    function automatic logic earlier(input logic [31:0] due_a, input logic [15:0] stamp_a,
                                     input logic [31:0] due_b, input logic [15:0] stamp_b,
                                     input logic [15:0] order);
        logic [15:0] age_a;
        logic [15:0] age_b;
        age_a = order - stamp_a;
        age_b = order - stamp_b;
        if (due_a != due_b) begin
            return due_a < due_b;
        end
        return age_a > age_b;
    endfunction

endpackage
`default_nettype wire

// File: hdl/tes_front.sv
// Input stage: takes items, computes the saturated due time and forwards commands.
`default_nettype none
module tes_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [2:0]    i_action,
    input  wire logic [15:0]   i_event_id,
    input  wire logic [23:0]   i_delay,
    input  wire logic [31:0]   i_current_time,
    output logic               o_push,
    output tes_pkg::t_cmd      o_cmd,
    input  wire logic          i_push_ready
);
    import tes_pkg::*;

    logic        r_valid;
    t_cmd        r_cmd;
    logic [32:0] sum;

    assign sum     = {1'b0, i_current_time} + {9'd0, i_delay};
    assign o_ready = !r_valid || i_push_ready;
    assign o_push  = r_valid && i_push_ready;
    assign o_cmd   = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_cmd.action <= i_action;
            r_cmd.id     <= i_event_id;
            r_cmd.due    <= sum[32] ? 32'hFFFF_FFFF : sum[31:0];
            r_cmd.now    <= i_current_time;
        end
    end
endmodule
`default_nettype wire

// File: hdl/tes_fifo.sv
// Two-entry queue between the front stage and the execution engine.
`default_nettype none
module tes_fifo #(
    parameter int WIDTH = 8
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output logic [WIDTH-1:0]      o_data,
    input  wire logic             i_pop
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end
endmodule
`default_nettype wire

// File: hdl/tes_back.sv
// Execution engine: holds the three stores, scans them and produces results.
`default_nettype none
module tes_back #(
    parameter int MAIN_DEPTH  = tes_pkg::MAIN_DEPTH_DEF,
    parameter int ROUND_DEPTH = tes_pkg::ROUND_DEPTH_DEF,
    parameter int IDLE_DEPTH  = tes_pkg::IDLE_DEPTH_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire tes_pkg::t_cmd i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  wire logic          i_ready,
    output logic [1:0]         o_kind,
    output logic [15:0]        o_fired_id,
    output logic [31:0]        o_fired_time,
    output logic               o_last,
    output logic               o_queue_empty,
    output logic               o_timeout_valid,
    output logic [32:0]        o_next_timeout
);
    import tes_pkg::*;

    localparam int SMAX = (MAIN_DEPTH > ROUND_DEPTH) ?
        ((MAIN_DEPTH > IDLE_DEPTH) ? MAIN_DEPTH : IDLE_DEPTH) :
        ((ROUND_DEPTH > IDLE_DEPTH) ? ROUND_DEPTH : IDLE_DEPTH);
    localparam int PW  = $clog2(SMAX + 1);
    localparam int MIW = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;
    localparam int RIW = (ROUND_DEPTH > 1) ? $clog2(ROUND_DEPTH) : 1;
    localparam int IIW = (IDLE_DEPTH > 1) ? $clog2(IDLE_DEPTH) : 1;
    localparam int MCW = $clog2(MAIN_DEPTH + 1);
    localparam int RCW = $clog2(ROUND_DEPTH + 1);
    localparam int ICW = $clog2(IDLE_DEPTH + 1);
    localparam int NW  = $clog2(MAX_RESULTS + 1);
    localparam logic [PW-1:0] MAIN_LAST = PW'(MAIN_DEPTH - 1);
    localparam logic [PW-1:0] IDLE_LAST = PW'(IDLE_DEPTH - 1);
    localparam logic [PW-1:0] SCAN_LAST = PW'(SMAX - 1);

    t_entry r_main  [MAIN_DEPTH];
    t_entry r_round [ROUND_DEPTH];
    t_entry r_idle  [IDLE_DEPTH];

    t_state r_state, n_state, r_ret, n_ret;
    t_cmd   r_cmd, n_cmd;
    logic [MCW-1:0] r_mc, n_mc;
    logic [RCW-1:0] r_rc, n_rc;
    logic [ICW-1:0] r_ic, n_ic;
    logic [15:0]    r_stamp, n_stamp;
    logic [PW-1:0]  r_ptr, n_ptr;
    logic [NW-1:0]  r_n, n_n;
    logic           r_fire, n_fire;
    logic           r_have, n_have;
    t_entry         r_best, n_best;
    logic [PW-1:0]  r_bidx, n_bidx;
    logic [1:0]     r_p_kind, n_p_kind;
    logic [15:0]    r_p_id, n_p_id;
    logic [31:0]    r_p_time, n_p_time;
    logic           r_p_qe, n_p_qe;
    logic           r_p_tv, n_p_tv;
    logic [32:0]    r_p_nt, n_p_nt;
    logic           r_p_last, n_p_last;
    logic           r_ovalid, n_ovalid;
    logic [1:0]     r_o_kind, n_o_kind;
    logic [15:0]    r_o_id, n_o_id;
    logic [31:0]    r_o_time, n_o_time;
    logic           r_o_last, n_o_last;
    logic           r_o_qe, n_o_qe;
    logic           r_o_tv, n_o_tv;
    logic [32:0]    r_o_nt, n_o_nt;

    logic           m_we, r_we, i_we;
    logic [MIW-1:0] m_wa;
    logic [RIW-1:0] r_wa;
    logic [IIW-1:0] i_wa;
    t_entry         m_wd, r_wd, i_wd;
    logic [MCW-1:0] mc_m1;
    logic [ICW-1:0] ic_m1;
    logic [MIW-1:0] m_ra;
    logic [IIW-1:0] i_ra;
    t_entry         main_rd, round_rd, idle_rd;
    logic           mv, rv, iv;

    assign mc_m1    = r_mc - 1'b1;
    assign ic_m1    = r_ic - 1'b1;
    assign m_ra     = (r_state == ST_REMOVE) ? mc_m1[MIW-1:0] : r_ptr[MIW-1:0];
    assign i_ra     = (r_state == ST_IMOVE) ? ic_m1[IIW-1:0] : r_ptr[IIW-1:0];
    assign main_rd  = r_main[m_ra];
    assign round_rd = r_round[r_ptr[RIW-1:0]];
    assign idle_rd  = r_idle[i_ra];
    assign mv       = r_ptr < PW'(r_mc);
    assign rv       = r_ptr < PW'(r_rc);
    assign iv       = r_ptr < PW'(r_ic);

    assign o_valid         = r_ovalid;
    assign o_kind          = r_o_kind;
    assign o_fired_id      = r_o_id;
    assign o_fired_time    = r_o_time;
    assign o_last          = r_o_last;
    assign o_queue_empty   = r_o_qe;
    assign o_timeout_valid = r_o_tv;
    assign o_next_timeout  = r_o_nt;

    always_comb begin
        logic          room;
        logic          v;
        logic [31:0]   b;
        logic          cond;
        n_state = r_state; n_ret = r_ret; n_cmd = r_cmd;
        n_mc = r_mc; n_rc = r_rc; n_ic = r_ic; n_stamp = r_stamp;
        n_ptr = r_ptr; n_n = r_n; n_fire = r_fire; n_have = r_have;
        n_best = r_best; n_bidx = r_bidx;
        n_p_kind = r_p_kind; n_p_id = r_p_id; n_p_time = r_p_time;
        n_p_qe = r_p_qe; n_p_tv = r_p_tv; n_p_nt = r_p_nt; n_p_last = r_p_last;
        n_ovalid = r_ovalid && !i_ready;
        n_o_kind = r_o_kind; n_o_id = r_o_id; n_o_time = r_o_time;
        n_o_last = r_o_last; n_o_qe = r_o_qe; n_o_tv = r_o_tv; n_o_nt = r_o_nt;
        m_we = 1'b0; m_wa = r_mc[MIW-1:0]; m_wd = '0;
        r_we = 1'b0; r_wa = r_rc[RIW-1:0]; r_wd = '0;
        i_we = 1'b0; i_wa = r_ic[IIW-1:0]; i_wd = '0;
        o_pop = 1'b0;
        room = 1'b0; v = r_have; b = r_best.due; cond = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    n_ptr = '0;
                    n_have = 1'b0;
                    n_n = '0;
                    n_fire = 1'b0;
                    n_p_kind = KIND_DONE;
                    n_p_id = '0;
                    n_p_time = '0;
                    n_state = ST_SUM;
                    m_wd = '{due: i_cmd.due, id: i_cmd.id, stamp: r_stamp};
                    r_wd = m_wd;
                    i_wd = m_wd;
                    unique case (i_cmd.action)
                        ACT_ADD: begin
                            room = ({1'b0, PW'(r_mc)} + {1'b0, PW'(r_rc)})
                                   < (PW + 1)'(MAIN_DEPTH);
                            m_we = room;
                        end
                        ACT_ADD_ROUND: begin
                            room = (({1'b0, PW'(r_mc)} + {1'b0, PW'(r_rc)})
                                   < (PW + 1)'(MAIN_DEPTH)) &&
                                   (r_rc < RCW'(ROUND_DEPTH));
                            r_we = room;
                        end
                        ACT_ADD_IDLE: begin
                            room = r_ic < ICW'(IDLE_DEPTH);
                            i_we = room;
                        end
                        ACT_TICK, ACT_FORCE: begin
                            n_fire = 1'b1;
                            n_state = ST_MERGE;
                        end
                        ACT_CLEAR: begin
                            n_mc = '0;
                            n_rc = '0;
                            n_ic = '0;
                        end
                        default: begin
                        end
                    endcase
                    if (room) begin
                        n_stamp = r_stamp + 16'd1;
                    end
                    if (m_we) n_mc = r_mc + 1'b1;
                    if (r_we) n_rc = r_rc + 1'b1;
                    if (i_we) n_ic = r_ic + 1'b1;
                    if (i_cmd.action == ACT_ADD || i_cmd.action == ACT_ADD_ROUND ||
                        i_cmd.action == ACT_ADD_IDLE) begin
                        n_p_kind = room ? KIND_DONE : KIND_FULL;
                    end
                end
            end
            ST_MERGE: begin
                if (rv) begin
                    if (r_mc < MCW'(MAIN_DEPTH)) begin
                        m_we = 1'b1;
                        m_wd = '{due: round_rd.due, id: round_rd.id, stamp: r_stamp};
                        n_mc = r_mc + 1'b1;
                        n_stamp = r_stamp + 16'd1;
                    end
                    n_ptr = r_ptr + 1'b1;
                end else begin
                    n_rc = '0;
                    n_ptr = '0;
                    n_have = 1'b0;
                    if (r_cmd.action == ACT_TICK && r_ic != '0 &&
                        r_mc < MCW'(MAIN_DEPTH)) begin
                        n_state = (r_mc == '0) ? ST_ISCAN : ST_IMIN;
                    end else begin
                        n_state = ST_FMIN;
                    end
                end
            end
            ST_IMIN, ST_FMIN: begin
                if (mv && (!r_have || earlier(main_rd.due, main_rd.stamp,
                                              r_best.due, r_best.stamp, r_stamp))) begin
                    n_have = 1'b1;
                    n_best = main_rd;
                    n_bidx = r_ptr;
                end
                n_ptr = r_ptr + 1'b1;
                if (r_ptr == MAIN_LAST) begin
                    n_ptr = '0;
                    if (r_state == ST_FMIN) begin
                        n_state = ST_FDEC;
                    end else if (n_best.due > r_cmd.now) begin
                        n_have = 1'b0;
                        n_state = ST_ISCAN;
                    end else begin
                        n_have = 1'b0;
                        n_state = ST_FMIN;
                    end
                end
            end
            ST_ISCAN: begin
                if (iv && (!r_have || earlier(idle_rd.due, idle_rd.stamp,
                                              r_best.due, r_best.stamp, r_stamp))) begin
                    n_have = 1'b1;
                    n_best = idle_rd;
                    n_bidx = r_ptr;
                end
                n_ptr = r_ptr + 1'b1;
                if (r_ptr == IDLE_LAST) begin
                    n_ptr = '0;
                    n_state = ST_IMOVE;
                end
            end
            ST_IMOVE: begin
                i_we = 1'b1;
                i_wa = r_bidx[IIW-1:0];
                i_wd = idle_rd;
                n_ic = ic_m1;
                m_we = 1'b1;
                m_wd = '{due: r_best.due, id: r_best.id, stamp: r_stamp};
                n_mc = r_mc + 1'b1;
                n_stamp = r_stamp + 16'd1;
                n_ptr = '0;
                n_have = 1'b0;
                n_state = ST_FMIN;
            end
            ST_FDEC: begin
                cond = r_have && (r_n < NW'(MAX_RESULTS)) &&
                       (r_cmd.action == ACT_FORCE || r_best.due <= r_cmd.now);
                if (r_n != '0) begin
                    n_p_last = !cond;
                    n_ret = cond ? ST_REMOVE : ST_IDLE;
                    n_state = ST_EMIT;
                end else if (cond) begin
                    n_state = ST_REMOVE;
                end else begin
                    n_p_kind = (r_cmd.action == ACT_FORCE) ? KIND_DONE : KIND_NONE;
                    n_p_id = '0;
                    n_p_time = '0;
                    n_fire = 1'b0;
                    n_ptr = '0;
                    n_have = 1'b0;
                    n_state = ST_SUM;
                end
            end
            ST_REMOVE: begin
                m_we = 1'b1;
                m_wa = r_bidx[MIW-1:0];
                m_wd = main_rd;
                n_mc = mc_m1;
                n_n = r_n + 1'b1;
                n_p_kind = KIND_FIRED;
                n_p_id = r_best.id;
                n_p_time = r_best.due;
                n_ptr = '0;
                n_have = 1'b0;
                n_state = ST_SUM;
            end
            ST_SUM: begin
                if (mv && (!v || main_rd.due < b)) begin
                    v = 1'b1;
                    b = main_rd.due;
                end
                if (rv && (!v || round_rd.due < b)) begin
                    v = 1'b1;
                    b = round_rd.due;
                end
                if (iv && (!v || idle_rd.due < b)) begin
                    v = 1'b1;
                    b = idle_rd.due;
                end
                n_have = v;
                n_best.due = b;
                n_ptr = r_ptr + 1'b1;
                if (r_ptr == SCAN_LAST) begin
                    n_ptr = '0;
                    n_p_qe = !v;
                    n_p_tv = v;
                    n_p_nt = v ? ({1'b0, b} - {1'b0, r_cmd.now}) : TIMEOUT_NONE;
                    n_have = 1'b0;
                    if (r_fire) begin
                        n_state = ST_FMIN;
                    end else begin
                        n_p_last = 1'b1;
                        n_ret = ST_IDLE;
                        n_state = ST_EMIT;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_ovalid || i_ready) begin
                    n_ovalid = 1'b1;
                    n_o_kind = r_p_kind;
                    n_o_id = r_p_id;
                    n_o_time = r_p_time;
                    n_o_last = r_p_last;
                    n_o_qe = r_p_qe;
                    n_o_tv = r_p_tv;
                    n_o_nt = r_p_nt;
                    n_state = r_ret;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ret    <= ST_IDLE;
            r_mc     <= '0;
            r_rc     <= '0;
            r_ic     <= '0;
            r_stamp  <= '0;
            r_ptr    <= '0;
            r_n      <= '0;
            r_fire   <= 1'b0;
            r_have   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ret    <= n_ret;
            r_mc     <= n_mc;
            r_rc     <= n_rc;
            r_ic     <= n_ic;
            r_stamp  <= n_stamp;
            r_ptr    <= n_ptr;
            r_n      <= n_n;
            r_fire   <= n_fire;
            r_have   <= n_have;
            r_ovalid <= n_ovalid;
        end
        r_cmd    <= n_cmd;
        r_best   <= n_best;
        r_bidx   <= n_bidx;
        r_p_kind <= n_p_kind;
        r_p_id   <= n_p_id;
        r_p_time <= n_p_time;
        r_p_qe   <= n_p_qe;
        r_p_tv   <= n_p_tv;
        r_p_nt   <= n_p_nt;
        r_p_last <= n_p_last;
        r_o_kind <= n_o_kind;
        r_o_id   <= n_o_id;
        r_o_time <= n_o_time;
        r_o_last <= n_o_last;
        r_o_qe   <= n_o_qe;
        r_o_tv   <= n_o_tv;
        r_o_nt   <= n_o_nt;
        if (m_we) r_main[m_wa] <= m_wd;
        if (r_we) r_round[r_wa] <= r_wd;
        if (i_we) r_idle[i_wa] <= i_wd;
    end
endmodule
`default_nettype wire

// File: hdl/timed_event_priority_scheduler.sv
// Top level of the timed event scheduler.
//
// Channel  | Dir | tdata (low bit up)                                   | tuser  | tlast
// s_axis   | in  | event_id 16, delay 24, current_time 32               | action | -
// m_axis   | out | fired_id 16, fired_time 32, queue_empty, timeout_valid,
//          |     | next_timeout 33, zero fill 5                         | kind   | last
//
// Each input is executed on its own. An add is followed by the summary scan, which covers
// the largest store depth at one entry per cycle. A tick or force empty first merges the
// round list into the main store, then for a tick may move one idle entry up (a main scan
// when the main store holds entries, an idle scan and a move), and then runs a main scan,
// a decision, a removal and a summary scan per fired event. A two-entry queue keeps
// taking input while the engine works. Reset is synchronous and active low and empties
// all stores. A stalled output holds its transfer and pauses the engine.
`default_nettype none
module timed_event_priority_scheduler #(
    parameter int MAIN_DEPTH  = tes_pkg::MAIN_DEPTH_DEF,
    parameter int ROUND_DEPTH = tes_pkg::ROUND_DEPTH_DEF,
    parameter int IDLE_DEPTH  = tes_pkg::IDLE_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [71:0] i_s_axis_tdata,  // event_id, delay, current_time
    input  wire logic [2:0]  i_s_axis_tuser,  // action
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [87:0]      o_m_axis_tdata,  // fired_id, fired_time, queue_empty,
                                              // timeout_valid, next_timeout
    output logic [1:0]       o_m_axis_tuser,  // kind
    output logic             o_m_axis_tlast
);
    import tes_pkg::*;

    logic        push, push_ready, q_valid, pop;
    t_cmd        f_cmd, q_cmd;
    logic [15:0] fired_id;
    logic [31:0] fired_time;
    logic        queue_empty, timeout_valid;
    logic [32:0] next_timeout;

    tes_front u_front (
        .i_clk, .i_rst_n,
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_action       (i_s_axis_tuser),
        .i_event_id     (i_s_axis_tdata[15:0]),
        .i_delay        (i_s_axis_tdata[39:16]),
        .i_current_time (i_s_axis_tdata[71:40]),
        .o_push         (push),
        .o_cmd          (f_cmd),
        .i_push_ready   (push_ready)
    );

    tes_fifo #(.WIDTH($bits(t_cmd))) u_fifo (
        .i_clk, .i_rst_n,
        .i_push  (push),
        .i_data  (f_cmd),
        .o_ready (push_ready),
        .o_valid (q_valid),
        .o_data  (q_cmd),
        .i_pop   (pop)
    );

    tes_back #(
        .MAIN_DEPTH (MAIN_DEPTH),
        .ROUND_DEPTH(ROUND_DEPTH),
        .IDLE_DEPTH (IDLE_DEPTH)
    ) u_back (
        .i_clk, .i_rst_n,
        .i_valid         (q_valid),
        .i_cmd           (q_cmd),
        .o_pop           (pop),
        .o_valid         (o_m_axis_tvalid),
        .i_ready         (i_m_axis_tready),
        .o_kind          (o_m_axis_tuser),
        .o_fired_id      (fired_id),
        .o_fired_time    (fired_time),
        .o_last          (o_m_axis_tlast),
        .o_queue_empty   (queue_empty),
        .o_timeout_valid (timeout_valid),
        .o_next_timeout  (next_timeout)
    );

    assign o_m_axis_tdata = {5'd0, next_timeout, timeout_valid, queue_empty,
                             fired_time, fired_id};
endmodule
`default_nettype wire

// File: hdl/tes_checker.sv
// Port-level checks of the scheduler and the bind that attaches them.
`default_nettype none
module tes_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [87:0] o_m_axis_tdata,
    input wire logic [1:0]  o_m_axis_tuser,
    input wire logic        o_m_axis_tlast
);
    import tes_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
        o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output changed while stalled");

    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != KIND_FIRED |-> o_m_axis_tdata[47:0] == 48'd0)
        else $error("fired fields set on a non-fired result");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[48] != o_m_axis_tdata[49])
        else $error("queue_empty disagrees with timeout_valid");

    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !o_m_axis_tdata[49] |-> o_m_axis_tdata[82:50] == TIMEOUT_NONE)
        else $error("timeout not saturated when empty");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != KIND_FIRED |-> o_m_axis_tlast)
        else $error("single result without last");
endmodule

bind timed_event_priority_scheduler tes_checker u_tes_checker (
    .i_clk, .i_rst_n, .o_m_axis_tvalid, .i_m_axis_tready,
    .o_m_axis_tdata, .o_m_axis_tuser, .o_m_axis_tlast
);
`default_nettype wire
